// ===== rtl/ucl_pkg.sv =====
// Shared types and constants of the UART command LED controller.
// Used by ucl_cmd_decode and uart_command_led_controller_unit; no dependencies.
`timescale 1ns / 1ps

package ucl_pkg;

	localparam int BUFFER_DEPTH_DEF = 128;
	localparam int HEAD_LEN         = 13;
	localparam int HEAD_IDX_W       = $clog2(HEAD_LEN);
	localparam int NUM_OUTS         = 4;
	localparam int PREFIX_LEN       = 6;

	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF     = 1'd1;
	localparam logic [CFG_W-1:0]     IDLE_TIMEOUT_RESET = 16'd500;
	localparam logic [CFG_W-1:0]     BLINK_HALF_RESET   = 16'd500;

	typedef logic [7:0] byte_t;
	typedef byte_t [HEAD_LEN-1:0] head_t;
	typedef byte_t [NUM_OUTS-1:0] mode_arr_t;

	localparam byte_t MODE_OFF   = 8'h30;
	localparam byte_t MODE_ON    = 8'h31;
	localparam byte_t MODE_BLINK = 8'h32;

	// ">OUTS:", first character in the lowest byte
	localparam logic [8*PREFIX_LEN-1:0] CMD_PREFIX =
		{8'h3A, 8'h53, 8'h54, 8'h55, 8'h4F, 8'h3E};

	localparam logic [3:0] LEVELS_RESET = 4'hF;

	typedef struct packed {
		logic      match;
		mode_arr_t modes;
	} cmd_t;

endpackage

// ===== rtl/uart_command_led_controller_unit.sv =====
// Top level of the UART command LED controller.
// Depends on ucl_pkg and ucl_cmd_decode.
`timescale 1ns / 1ps

// Usage:
//   Slave channel (s_axis_*): one item per handshake; tuser says what it is
//   (0 millisecond tick, 1 received UART byte), tdata carries the byte.
//   Master channel (m_axis_*): exactly one result item per input item, in
//   order: LED levels (active low), ack, packet-closed flag and length.
//   Configuration: cfg_wr_en writes cfg_data into register cfg_index
//   (0 idle timeout in ticks, 1 blink half period in ticks); write only
//   while no item is in flight.
// Pipeline: an accepted item is loaded into the input register; the state
//   update and the result register are loaded from it as soon as the result
//   register is empty or being taken.
// Throughput: one item per cycle unless stalled; the whole update of counters,
//   packet head and command decode is one combinational pass from the input register.
// Reset: arst_n clears the packet state, blink divider and pipeline valids,
//   sets all modes to off, all LEDs off and both registers to 500.
// Stall: while m_axis_tready is low the result register holds; one more
//   item is taken into the input register, then s_axis_tready drops.
module uart_command_led_controller_unit #(
	parameter int BUFFER_DEPTH = ucl_pkg::BUFFER_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // [7:0] rx_byte
	input  logic [0:0]                     s_axis_tuser,  // [0] opcode
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [3:0] led_levels, [4] ok_ack, [5] packet_closed, [13:6] packet_length,
	// [15:14] zero
	output logic [15:0]                    m_axis_tdata,
	input  logic                           cfg_wr_en,
	input  logic [ucl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ucl_pkg::CFG_W-1:0]      cfg_data
);
	import ucl_pkg::*;

	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

	// configuration
	logic [CFG_W-1:0] idle_timeout_q;
	logic [CFG_W-1:0] blink_half_q;

	// input register
	logic             s1_valid_s1;
	logic             opcode_s1;
	byte_t            rx_byte_s1;

	// block state
	head_t            head_q;
	logic [CNT_W-1:0] byte_count_q;
	logic             open_q;
	logic [15:0]      idle_left_q;
	logic [15:0]      blink_ticks_q;
	logic             blink_phase_q;
	mode_arr_t        mode_q;
	logic [3:0]       levels_q;

	// result register
	logic             out_valid_q;
	logic [15:0]      out_data_q;

	logic             adv;

	// next-state values
	head_t            head_n;
	logic [CNT_W-1:0] count_n;
	logic [CNT_W-1:0] count_upd;
	logic             open_n;
	logic [15:0]      idle_n;
	logic [15:0]      idle_upd;
	logic [15:0]      ticks_n;
	logic [15:0]      ticks_inc;
	logic             phase_n;
	logic             closing;
	logic             ack;
	mode_arr_t        mode_n;
	logic [3:0]       levels_n;
	logic [CNT_W+7:0] count_ext;
	logic [7:0]       plen;
	logic             head_wr;
	cmd_t             cmd;

	assign adv           = s1_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_s1 || adv;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_timeout_q <= IDLE_TIMEOUT_RESET;
			blink_half_q   <= BLINK_HALF_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_IDLE_TIMEOUT: idle_timeout_q <= cfg_data;
				REG_BLINK_HALF:   blink_half_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			opcode_s1  <= s_axis_tuser[0];
			rx_byte_s1 <= s_axis_tdata;
		end
	end

	// store the byte into the head while fewer than HEAD_LEN have arrived
	assign head_wr = opcode_s1 && (byte_count_q < CNT_W'(HEAD_LEN));

	always_comb begin
		for (int i = 0; i < HEAD_LEN; i++) begin
			head_n[i] = (head_wr && byte_count_q[HEAD_IDX_W-1:0] == HEAD_IDX_W'(i))
				? rx_byte_s1 : head_q[i];
		end
	end

	always_comb begin
		count_upd = byte_count_q;
		idle_upd  = idle_left_q;
		ticks_n   = blink_ticks_q;
		phase_n   = blink_phase_q;
		ticks_inc = blink_ticks_q + 16'd1;
		if (opcode_s1) begin
			if (byte_count_q < CNT_W'(BUFFER_DEPTH)) begin
				count_upd = byte_count_q + CNT_W'(1);
			end
			idle_upd = idle_timeout_q;
		end else begin
			if (open_q && idle_left_q != 16'd0) begin
				idle_upd = idle_left_q - 16'd1;
			end
			if (ticks_inc >= blink_half_q) begin
				ticks_n = 16'd0;
				phase_n = !blink_phase_q;
			end else begin
				ticks_n = ticks_inc;
			end
		end
	end

	assign closing = (open_q || opcode_s1)
		&& (idle_upd == 16'd0 || count_upd >= CNT_W'(BUFFER_DEPTH));

	ucl_cmd_decode u_decode (
		.head        (head_n),
		.long_enough (count_upd >= CNT_W'(HEAD_LEN)),
		.cmd         (cmd)
	);

	assign ack       = closing && cmd.match;
	assign mode_n    = ack ? cmd.modes : mode_q;
	assign count_n   = closing ? '0 : count_upd;
	assign idle_n    = closing ? 16'd0 : idle_upd;
	assign open_n    = !closing && (open_q || opcode_s1);
	assign count_ext = {8'd0, count_upd};
	assign plen      = closing ? count_ext[7:0] : 8'd0;

	always_comb begin
		for (int i = 0; i < NUM_OUTS; i++) begin
			unique case (mode_n[i])
				MODE_OFF:   levels_n[i] = 1'b1;
				MODE_ON:    levels_n[i] = 1'b0;
				MODE_BLINK: levels_n[i] = phase_n;
				default:    levels_n[i] = levels_q[i];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= '0;
			open_q        <= 1'b0;
			idle_left_q   <= 16'd0;
			blink_ticks_q <= 16'd0;
			blink_phase_q <= 1'b0;
			mode_q        <= {NUM_OUTS{MODE_OFF}};
			levels_q      <= LEVELS_RESET;
		end else if (adv) begin
			byte_count_q  <= count_n;
			open_q        <= open_n;
			idle_left_q   <= idle_n;
			blink_ticks_q <= ticks_n;
			blink_phase_q <= phase_n;
			mode_q        <= mode_n;
			levels_q      <= levels_n;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			head_q <= head_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {2'b00, plen, closing, ack, levels_n};
		end
	end

	// a closed packet leaves no idle count and no byte count behind
	a_closed_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!open_q |-> (idle_left_q == 16'd0 && byte_count_q == '0))
		else $error("idle packet state not cleared");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= CNT_W'(BUFFER_DEPTH))
		else $error("byte count beyond buffer depth");

	a_ack_closed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_data_q[4] || out_data_q[5]))
		else $error("ack without a closed packet");

	a_len_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_data_q[5]) |-> out_data_q[13:6] == 8'd0)
		else $error("length reported without a closed packet");

	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("processed item produced no result");

endmodule

// ===== rtl/ucl_cmd_decode.sv =====
// Command decoder: checks the packet head for the OUTS prefix and picks the modes.
// Depends on ucl_pkg.
`timescale 1ns / 1ps

module ucl_cmd_decode (
	input  ucl_pkg::head_t head,
	input  logic           long_enough,
	output ucl_pkg::cmd_t  cmd
);
	import ucl_pkg::*;

	always_comb begin
		cmd.match = long_enough && (head[PREFIX_LEN-1:0] == CMD_PREFIX);
		for (int i = 0; i < NUM_OUTS; i++) begin
			cmd.modes[i] = head[PREFIX_LEN + 2 * i];
		end
	end

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for uart_command_led_controller_unit.
// Depends on ucl_pkg and the RTL; predicts every result item and checks it on the
// master stream while both stream sides idle and stall at random, apart from tests that turn this off.
`timescale 1ns / 1ps

module testbench;
	import ucl_pkg::*;

	localparam int DEPTH       = BUFFER_DEPTH_DEF;
	localparam int HOLD_CYCLES = 200;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_BYTE   = 1'b1;

	typedef struct packed {
		logic [7:0] length;
		logic       closed;
		logic       ack;
		logic [3:0] levels;
	} led_result_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata;   // [7:0] rx_byte
	logic [0:0]        s_axis_tuser;   // [0] opcode
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	// [3:0] led_levels, [4] ok_ack, [5] packet_closed, [13:6] packet_length
	logic [15:0]       m_axis_tdata;
	logic              cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]  cfg_data;

	// predictor state
	logic [CFG_W-1:0] cfg_timeout;
	logic [CFG_W-1:0] cfg_blink;
	byte_t            head_bytes [HEAD_LEN];
	int               pkt_bytes;
	logic             pkt_open;
	logic [15:0]      idle_left;
	logic [15:0]      blink_ticks;
	logic             blink_phase;
	byte_t            mode_sel [NUM_OUTS];
	logic [3:0]       led_level;

	led_result_t expected_results[$];
	int          items_sent;
	int          results_checked;
	int          packets_closed;
	int          commands_taken;
	int          mismatches;
	int unsigned cycle_cnt;
	bit          src_idle;
	bit          sink_idle;
	bit          hold_req;

	uart_command_led_controller_unit #(
		.BUFFER_DEPTH(DEPTH)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void reset_controller_model();
		int i;
		cfg_timeout = IDLE_TIMEOUT_RESET;
		cfg_blink   = BLINK_HALF_RESET;
		for (i = 0; i < HEAD_LEN; i++)
			head_bytes[i] = '0;
		pkt_bytes   = 0;
		pkt_open    = 1'b0;
		idle_left   = '0;
		blink_ticks = '0;
		blink_phase = 1'b0;
		for (i = 0; i < NUM_OUTS; i++)
			mode_sel[i] = MODE_OFF;
		led_level = LEVELS_RESET;
	endfunction

	function automatic led_result_t led_controller_step(input logic op, input byte_t rx);
		led_result_t r;
		logic        prefix_ok;
		int          i;
		r = '0;
		if (op == OP_BYTE) begin
			if (pkt_bytes < HEAD_LEN)
				head_bytes[pkt_bytes] = rx;
			if (pkt_bytes < DEPTH)
				pkt_bytes++;
			idle_left = cfg_timeout;
			pkt_open  = 1'b1;
		end else begin
			if (pkt_open && idle_left != 0)
				idle_left--;
			blink_ticks++;
			if (blink_ticks >= cfg_blink) begin
				blink_ticks = '0;
				blink_phase = ~blink_phase;
			end
		end
		// close on idle timeout or full buffer, then decode the head
		if (pkt_open && (idle_left == 0 || pkt_bytes >= DEPTH)) begin
			r.closed  = 1'b1;
			r.length  = pkt_bytes[7:0];
			prefix_ok = (pkt_bytes >= HEAD_LEN);
			for (i = 0; i < PREFIX_LEN; i++)
				if (head_bytes[i] != CMD_PREFIX[8*i +: 8])
					prefix_ok = 1'b0;
			if (prefix_ok) begin
				r.ack = 1'b1;
				for (i = 0; i < NUM_OUTS; i++)
					mode_sel[i] = head_bytes[6 + 2*i];
			end
			pkt_bytes = 0;
			pkt_open  = 1'b0;
			idle_left = '0;
		end
		for (i = 0; i < NUM_OUTS; i++)
			case (mode_sel[i])
				MODE_OFF:   led_level[i] = 1'b1;
				MODE_ON:    led_level[i] = 1'b0;
				MODE_BLINK: led_level[i] = blink_phase;
				default:    ;
			endcase
		r.levels = led_level;
		return r;
	endfunction

	function automatic byte_t pick_mode();
		case ($urandom_range(0, 9))
			0, 1, 2: return MODE_OFF;
			3, 4, 5: return MODE_ON;
			6, 7, 8: return MODE_BLINK;
			default: return byte_t'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_item(input logic op, input byte_t rx);
		int gap;
		if (src_idle && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= rx;
		do
			@(posedge clk);
		while (s_axis_tready !== 1'b1);
		expected_results.push_back(led_controller_step(op, rx));
		items_sent++;
	endtask

	// drop valid and wait until every expected result item has come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_IDLE_TIMEOUT)
			cfg_timeout = val;
		else
			cfg_blink = val;
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_item(OP_TICK, byte_t'($urandom_range(0, 255)));
	endtask

	task automatic send_string(input byte_t bytes[$]);
		foreach (bytes[k])
			send_item(OP_BYTE, bytes[k]);
	endtask

	// one packet: mostly OUTS commands, some truncated, corrupted or plain noise
	task automatic send_frame();
		byte_t frame_q[$];
		int    kind;
		int    len;
		int    k;
		byte_t b;
		kind = $urandom_range(0, 9);
		if (kind <= 5)
			len = HEAD_LEN + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0);
		else if (kind <= 7)
			len = $urandom_range(1, HEAD_LEN - 1);
		else if (kind == 8)
			len = HEAD_LEN;
		else
			len = $urandom_range(1, 20);
		for (k = 0; k < len; k++) begin
			if (kind <= 8 && k < PREFIX_LEN)
				b = CMD_PREFIX[8*k +: 8];
			else if (kind <= 8 && k < HEAD_LEN && k % 2 == 0)
				b = pick_mode();
			else
				b = byte_t'($urandom_range(0, 255));
			frame_q.push_back(b);
		end
		if (kind == 8) begin
			k = $urandom_range(0, PREFIX_LEN - 1);
			frame_q[k] = frame_q[k] ^ (8'h01 << $urandom_range(0, 7));
		end
		foreach (frame_q[i]) begin
			send_item(OP_BYTE, frame_q[i]);
			// short silences that keep the packet open
			if (cfg_timeout > 1 && $urandom_range(0, 3) == 0)
				send_ticks($urandom_range(1, int'(cfg_timeout) - 1));
		end
		send_ticks(int'(cfg_timeout) + $urandom_range(0, 3));
	endtask

	task automatic test_reset_state();
		send_ticks(3);
		send_item(OP_BYTE, 8'h00);
	endtask

	task automatic test_zero_timeout();
		write_reg(REG_IDLE_TIMEOUT, 16'd0);
		write_reg(REG_BLINK_HALF, 16'd0);
		send_item(OP_BYTE, 8'hFF);
		send_ticks(2);
	endtask

	task automatic test_command_decode();
		write_reg(REG_IDLE_TIMEOUT, 16'd2);
		send_string('{8'h3E, 8'h4F, 8'h55, 8'h54, 8'h53, 8'h3A,
			MODE_ON, 8'h00, MODE_OFF, 8'h80, MODE_BLINK, 8'h7F, 8'h39});
		send_ticks(4);
	endtask

	task automatic test_short_packet();
		send_string('{8'h41, 8'h42});
		send_ticks(2);
	endtask

	task automatic test_random_frames(input int item_goal);
		int tmo;
		int half;
		while (items_sent < item_goal) begin
			tmo  = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
			half = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
			write_reg(REG_IDLE_TIMEOUT, CFG_W'(tmo));
			write_reg(REG_BLINK_HALF, CFG_W'(half));
			repeat (8) send_frame();
		end
	endtask

	// two full-buffer packets, the first an OUTS command; the result side holds off
	task automatic test_long_packets();
		int    k;
		byte_t b;
		write_reg(REG_IDLE_TIMEOUT, 16'hFFFF);
		write_reg(REG_BLINK_HALF, 16'hFFFF);
		src_idle = 1'b0;
		hold_req = 1'b1;
		for (k = 0; k < 2 * DEPTH; k++) begin
			if (k < PREFIX_LEN)
				b = CMD_PREFIX[8*k +: 8];
			else if (k < HEAD_LEN && k % 2 == 0)
				b = pick_mode();
			else
				b = byte_t'($urandom_range(0, 255));
			send_item(OP_BYTE, b);
			if (k % 16 == 15)
				send_ticks(1);
		end
		src_idle = 1'b1;
	endtask

	task automatic test_random_no_idle(input int item_goal);
		wait_drained();
		src_idle  = 1'b0;
		sink_idle = 1'b0;
		test_random_frames(item_goal);
	endtask

	task automatic flag_mismatch(input string field, input int want, input int got);
		mismatches++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
	endtask

	always @(posedge clk) begin : check_results
		led_result_t got;
		led_result_t want;
		if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
			got = m_axis_tdata[13:0];
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t: result item with nothing expected, actual %h", $time, got);
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (want.closed)
					packets_closed++;
				if (want.ack)
					commands_taken++;
				if (got.levels !== want.levels)
					flag_mismatch("led_levels", want.levels, got.levels);
				if (got.ack !== want.ack)
					flag_mismatch("ok_ack", want.ack, got.ack);
				if (got.closed !== want.closed)
					flag_mismatch("packet_closed", want.closed, got.closed);
				if (got.length !== want.length)
					flag_mismatch("packet_length", want.length, got.length);
			end
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin : result_sink
		int n;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (sink_idle && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				n = $urandom_range(1, 18);
				repeat (n) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("uart_command_led_controller_unit test failed");
			$finish;
		end
	end

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		cfg_wr_en     <= 1'b0;
		cfg_index     <= '0;
		cfg_data      <= '0;
		items_sent      = 0;
		results_checked = 0;
		packets_closed  = 0;
		commands_taken  = 0;
		mismatches      = 0;
		cycle_cnt       = 0;
		src_idle        = 1'b1;
		sink_idle       = 1'b1;
		hold_req        = 1'b0;
		reset_controller_model();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_state();
		test_zero_timeout();
		test_command_decode();
		test_short_packet();
		test_random_frames(650);
		test_long_packets();
		test_random_frames(1050);
		test_random_no_idle(1250);

		wait_drained();
		repeat (10) @(posedge clk);
		$display("Sent %0d items and checked %0d results: %0d packets closed, %0d commands taken,",
			items_sent, results_checked, packets_closed, commands_taken);
		$display("over idle timeouts from 0 to 65535 and blink half periods from 0 to 65535.");
		if (mismatches == 0 && expected_results.size() == 0)
			$display("uart_command_led_controller_unit test passed");
		else
			$display("uart_command_led_controller_unit test failed");
		$finish;
	end

endmodule
